[design/ide_pkg.sv]
`default_nettype none

package ide_pkg;

   localparam int unsigned TEXT_LEN             = 19;
   localparam int unsigned POS_W                = 5;
   localparam int unsigned CHAR_W               = 8;
   localparam int unsigned YEAR_W               = 14;
   localparam int unsigned FIELD_W              = 7;
   localparam int unsigned EPOCH_W              = 31;
   localparam int unsigned STATUS_W             = 3;
   localparam int unsigned FAULT_W              = 2;
   localparam int unsigned FAULT_SEP            = 1;
   localparam int unsigned FAULT_DIGIT          = 0;
   localparam int unsigned FIRST_YEAR           = 1970;
   localparam int unsigned BASE_YEAR            = 1900;
   localparam int unsigned LAST_YEAR_OFFSET_DEF = 133;
   localparam int unsigned DAY_SECONDS          = 86400;
   localparam int unsigned HOUR_SECONDS         = 3600;
   localparam int unsigned MINUTE_SECONDS       = 60;
   localparam int unsigned HMS_W                = 17;
   localparam int unsigned QUEUE_DEPTH          = 2;

   localparam logic [POS_W-1:0] POS_DASH_A  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_DASH_B  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_T       = POS_W'(10);
   localparam logic [POS_W-1:0] POS_COLON_A = POS_W'(13);
   localparam logic [POS_W-1:0] POS_COLON_B = POS_W'(16);

   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_SEPARATOR = 3'd2,
      ST_DIGIT     = 3'd3,
      ST_RANGE     = 3'd4,
      ST_PAST_END  = 3'd5
   } status_type;

   typedef struct packed {
      logic                short_text;
      logic [FAULT_W-1:0]  fault;
      logic [YEAR_W-1:0]   year;
      logic [FIELD_W-1:0]  month;
      logic [FIELD_W-1:0]  day;
      logic [FIELD_W-1:0]  hour;
      logic [FIELD_W-1:0]  minute;
      logic [FIELD_W-1:0]  second;
   } record_type;

   function automatic logic [8:0] month_first_day(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] d;
      case (m)
         4'd1:                    d = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[design/ide_req_if.sv]
`default_nettype none

interface ide_req_if;
   import ide_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);

endinterface

`default_nettype wire

[design/ide_rsp_if.sv]
`default_nettype none

interface ide_rsp_if;
   import ide_pkg::*;

   logic                valid;
   logic                ready;
   logic [EPOCH_W-1:0]  epoch_seconds;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output epoch_seconds, output status, input ready);
   modport sink   (input valid, input epoch_seconds, input status, output ready);

endinterface

`default_nettype wire

[design/iso_date_to_epoch_top.sv]
// A result reaches rsp via the queue and the stage 1, stage 2 and output registers.
// Throughput: one character per cycle; one result per cycle when rsp is ready.
// req stalls only when the two-entry record queue is full.
// The back pipeline stalls as a whole while the output register holds an untaken result.
// Synchronous active-high reset clears accumulators, queue and valid flags; no clearing pass.
`default_nettype none

module iso_date_to_epoch_top #(
   parameter int unsigned LAST_YEAR_OFFSET = ide_pkg::LAST_YEAR_OFFSET_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ide_req_if.sink     req_if,
   ide_rsp_if.source   rsp_if
);
   import ide_pkg::*;

   logic        push;
   record_type  push_rec;
   logic        queue_full;
   logic        head_vld;
   record_type  head_rec;
   logic        pop;

   ide_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_rec   (push_rec)
   );

   ide_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (queue_full),
      .head_vld (head_vld),
      .head_rec (head_rec),
      .pop      (pop)
   );

   ide_back #(
      .LAST_YEAR_OFFSET (LAST_YEAR_OFFSET)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_vld (head_vld),
      .head_rec (head_rec),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

[design/ide_front.sv]
`default_nettype none

module ide_front (
   input  wire logic               clock,
   input  wire logic               reset,
   ide_req_if.sink                 req_if,
   input  wire logic               queue_full,
   output logic                    push,
   output ide_pkg::record_type     push_rec
);
   import ide_pkg::*;

   logic [POS_W-1:0]   position_ff,  position_in,  position_t;
   logic [YEAR_W-1:0]  year_ff,      year_in,      year_t;
   logic [FIELD_W-1:0] month_ff,     month_in,     month_t;
   logic [FIELD_W-1:0] day_ff,       day_in,       day_t;
   logic [FIELD_W-1:0] hour_ff,      hour_in,      hour_t;
   logic [FIELD_W-1:0] minute_ff,    minute_in,    minute_t;
   logic [FIELD_W-1:0] second_ff,    second_in,    second_t;
   logic [FAULT_W-1:0] fault_ff,     fault_in,     fault_t;
   logic               accept;
   logic               is_digit;
   logic [3:0]         digit;

   function automatic logic [YEAR_W-1:0] push_digit(input logic [YEAR_W-1:0] acc,
                                                    input logic [3:0] d);
      logic [YEAR_W+3:0] sum;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {(YEAR_W)'(0), d};
      return sum[YEAR_W-1:0];
   endfunction

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign is_digit     = (req_if.character >= CHAR_ZERO) && (req_if.character <= CHAR_NINE);
   assign digit        = req_if.character[3:0];

   always_comb begin
      position_t = position_ff;
      year_t     = year_ff;
      month_t    = month_ff;
      day_t      = day_ff;
      hour_t     = hour_ff;
      minute_t   = minute_ff;
      second_t   = second_ff;
      fault_t    = fault_ff;
      if (position_ff < POS_W'(TEXT_LEN)) begin
         position_t = position_ff + POS_W'(1);
         case (position_ff) inside
            POS_DASH_A, POS_DASH_B: begin
               if (req_if.character != CHAR_DASH) fault_t[FAULT_SEP] = 1'b1;
            end
            POS_T: begin
               if (req_if.character != CHAR_T) fault_t[FAULT_SEP] = 1'b1;
            end
            POS_COLON_A, POS_COLON_B: begin
               if (req_if.character != CHAR_COLON) fault_t[FAULT_SEP] = 1'b1;
            end
            default: begin
               if (!is_digit) begin
                  fault_t[FAULT_DIGIT] = 1'b1;
               end else if (position_ff < POS_DASH_A) begin
                  year_t = push_digit(year_ff, digit);
               end else if (position_ff < POS_DASH_B) begin
                  month_t = FIELD_W'(push_digit(YEAR_W'(month_ff), digit));
               end else if (position_ff < POS_T) begin
                  day_t = FIELD_W'(push_digit(YEAR_W'(day_ff), digit));
               end else if (position_ff < POS_COLON_A) begin
                  hour_t = FIELD_W'(push_digit(YEAR_W'(hour_ff), digit));
               end else if (position_ff < POS_COLON_B) begin
                  minute_t = FIELD_W'(push_digit(YEAR_W'(minute_ff), digit));
               end else begin
                  second_t = FIELD_W'(push_digit(YEAR_W'(second_ff), digit));
               end
            end
         endcase
      end
   end

   // restart after the last beat of a string
   always_comb begin
      position_in = position_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      hour_in     = hour_ff;
      minute_in   = minute_ff;
      second_in   = second_ff;
      fault_in    = fault_ff;
      if (accept) begin
         if (req_if.last) begin
            position_in = '0;
            year_in     = '0;
            month_in    = '0;
            day_in      = '0;
            hour_in     = '0;
            minute_in   = '0;
            second_in   = '0;
            fault_in    = '0;
         end else begin
            position_in = position_t;
            year_in     = year_t;
            month_in    = month_t;
            day_in      = day_t;
            hour_in     = hour_t;
            minute_in   = minute_t;
            second_in   = second_t;
            fault_in    = fault_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         year_ff     <= '0;
         month_ff    <= '0;
         day_ff      <= '0;
         hour_ff     <= '0;
         minute_ff   <= '0;
         second_ff   <= '0;
         fault_ff    <= '0;
      end else begin
         position_ff <= position_in;
         year_ff     <= year_in;
         month_ff    <= month_in;
         day_ff      <= day_in;
         hour_ff     <= hour_in;
         minute_ff   <= minute_in;
         second_ff   <= second_in;
         fault_ff    <= fault_in;
      end
   end

   assign push                = accept && req_if.last;
   assign push_rec.short_text = position_t < POS_W'(TEXT_LEN);
   assign push_rec.fault      = fault_t;
   assign push_rec.year       = year_t;
   assign push_rec.month      = month_t;
   assign push_rec.day        = day_t;
   assign push_rec.hour       = hour_t;
   assign push_rec.minute     = minute_t;
   assign push_rec.second     = second_t;

endmodule

`default_nettype wire

[design/ide_queue.sv]
`default_nettype none

module ide_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ide_pkg::record_type push_rec,
   output logic                     full,
   output logic                     head_vld,
   output ide_pkg::record_type      head_rec,
   input  wire logic                pop
);
   import ide_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   record_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_vld = count_ff != '0;
   assign head_rec = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && head_vld;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

[design/ide_back.sv]
`default_nettype none

module ide_back #(
   parameter int unsigned LAST_YEAR_OFFSET = ide_pkg::LAST_YEAR_OFFSET_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_vld,
   input  wire ide_pkg::record_type head_rec,
   output logic                     pop,
   ide_rsp_if.source                rsp_if
);
   import ide_pkg::*;

   localparam int unsigned LAST_YEAR = BASE_YEAR + LAST_YEAR_OFFSET;
   localparam int unsigned YOFF_W    = $clog2(LAST_YEAR - FIRST_YEAR + 2);
   localparam int unsigned MAX_DAYS  = (LAST_YEAR - FIRST_YEAR + 1) * 366;
   localparam int unsigned DAYS_W    = $clog2(MAX_DAYS + 1);
   localparam int unsigned SECS_W    = DAYS_W + HMS_W + 1;

   logic                advance;
   logic                s1_vld_ff, s2_vld_ff, out_vld_ff;

   // stage 1: status by priority, day count up to month start, month length
   logic                range_bad;
   logic                leap_year;
   logic [3:0]          m_idx;
   logic [YOFF_W-1:0]   year_off;
   status_type          s1_status_in, s1_status_ff;
   logic [DAYS_W-1:0]   s1_days_in,   s1_days_ff;
   logic [4:0]          s1_dim_in,    s1_dim_ff;
   logic [4:0]          s1_day_ff;
   logic [4:0]          s1_hour_ff;
   logic [5:0]          s1_minute_ff;
   logic [5:0]          s1_second_ff;

   // stage 2: time of day, day total, month end check
   status_type          s2_status_in, s2_status_ff;
   logic [DAYS_W-1:0]   s2_total_in,  s2_total_ff;
   logic [HMS_W-1:0]    s2_hms_in,    s2_hms_ff;
   logic                past_end;

   // stage 3: epoch seconds
   logic [SECS_W-1:0]   secs_full;
   status_type          status_ff;
   logic [EPOCH_W-1:0]  epoch_in, epoch_ff;

   assign advance = !out_vld_ff || rsp_if.ready;
   assign pop     = head_vld && advance;

   always_comb begin
      range_bad = (head_rec.year < YEAR_W'(FIRST_YEAR)) || (head_rec.year > YEAR_W'(LAST_YEAR))
               || (head_rec.month < FIELD_W'(1)) || (head_rec.month > FIELD_W'(12))
               || (head_rec.day < FIELD_W'(1)) || (head_rec.day > FIELD_W'(31))
               || (head_rec.hour > FIELD_W'(23)) || (head_rec.minute > FIELD_W'(59))
               || (head_rec.second > FIELD_W'(60));
      if (head_rec.short_text)            s1_status_in = ST_SHORT;
      else if (head_rec.fault[FAULT_SEP]) s1_status_in = ST_SEPARATOR;
      else if (head_rec.fault[FAULT_DIGIT]) s1_status_in = ST_DIGIT;
      else if (range_bad)                 s1_status_in = ST_RANGE;
      else                                s1_status_in = ST_OK;

      m_idx     = head_rec.month[3:0] - 4'd1;
      leap_year = head_rec.year[1:0] == 2'b00;
      year_off  = YOFF_W'(head_rec.year - YEAR_W'(FIRST_YEAR));
      // leap days before the year: (year - 1969) / 4 counted from 1970
      s1_days_in = DAYS_W'(DAYS_W'(year_off) * DAYS_W'(365))
                 + DAYS_W'((year_off + YOFF_W'(1)) >> 2)
                 + DAYS_W'(month_first_day(m_idx))
                 + DAYS_W'(leap_year && (m_idx >= 4'd2));
      s1_dim_in  = month_days(m_idx) + 5'(leap_year && (m_idx == 4'd1));
   end

   always_comb begin
      s2_hms_in = HMS_W'(HMS_W'(s1_hour_ff) * HMS_W'(HOUR_SECONDS))
                + HMS_W'(HMS_W'(s1_minute_ff) * HMS_W'(MINUTE_SECONDS))
                + HMS_W'(s1_second_ff);
      s2_total_in = s1_days_ff + DAYS_W'(s1_day_ff) - DAYS_W'(1);
      past_end = (s1_day_ff > s1_dim_ff)
              || ((s1_day_ff == s1_dim_ff) && (s2_hms_in == HMS_W'(DAY_SECONDS)));
      s2_status_in = ((s1_status_ff == ST_OK) && past_end) ? ST_PAST_END : s1_status_ff;
   end

   always_comb begin
      secs_full = SECS_W'(SECS_W'(s2_total_ff) * SECS_W'(DAY_SECONDS)) + SECS_W'(s2_hms_ff);
      epoch_in  = (s2_status_ff == ST_OK) ? EPOCH_W'(secs_full) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= head_vld;
         s2_vld_ff  <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_status_ff <= s1_status_in;
         s1_days_ff   <= s1_days_in;
         s1_dim_ff    <= s1_dim_in;
         s1_day_ff    <= head_rec.day[4:0];
         s1_hour_ff   <= head_rec.hour[4:0];
         s1_minute_ff <= head_rec.minute[5:0];
         s1_second_ff <= head_rec.second[5:0];
         s2_status_ff <= s2_status_in;
         s2_total_ff  <= s2_total_in;
         s2_hms_ff    <= s2_hms_in;
         status_ff    <= s2_status_ff;
         epoch_ff     <= epoch_in;
      end
   end

   assign rsp_if.valid         = out_vld_ff;
   assign rsp_if.epoch_seconds = epoch_ff;
   assign rsp_if.status        = status_ff;

`ifndef SYNTHESIS
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (status_ff != ST_OK)) |-> (epoch_ff == '0))
      else $error("nonzero epoch with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.status <= STATUS_W'(ST_PAST_END)))
      else $error("status code out of range");

   a_head_load: assert property (@(posedge clock) disable iff (reset)
      (head_vld && advance) |=> s1_vld_ff)
      else $error("popped record lost at stage 1");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && !advance) |=> (s2_vld_ff && $stable(s2_total_ff)))
      else $error("stage 2 moved during stall");
`endif

endmodule

`default_nettype wire

[tb/iso_date_to_epoch_top_test.sv]
`timescale 1ns / 1ps

module iso_date_to_epoch_top_test;
   import ide_pkg::*;

   typedef logic [CHAR_W-1:0] text_type[$];

   typedef struct {
      logic [EPOCH_W-1:0] epoch;
      status_type         status;
   } stamp_type;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_CHARS   = 1050;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned STALL_PERCENT  = 8;
   localparam int unsigned LAST_YEAR      = BASE_YEAR + LAST_YEAR_OFFSET_DEF;
   localparam int unsigned DAYS_BEFORE_MONTH [13] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

   logic clock;
   logic reset;

   ide_req_if req_bus ();
   ide_rsp_if rsp_bus ();

   iso_date_to_epoch_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   logic [POS_W-1:0]   text_pos;
   logic [YEAR_W-1:0]  year_acc;
   logic [FIELD_W-1:0] month_acc;
   logic [FIELD_W-1:0] day_acc;
   logic [FIELD_W-1:0] hour_acc;
   logic [FIELD_W-1:0] minute_acc;
   logic [FIELD_W-1:0] second_acc;
   logic [FAULT_W-1:0] fault_flags;

   stamp_type expected_stamps[$];
   bit     calm;
   int     errors;
   int     chars_sent;
   int     stamps_checked;
   int     status_seen [6];
   int     quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_state();
      text_pos    = '0;
      year_acc    = '0;
      month_acc   = '0;
      day_acc     = '0;
      hour_acc    = '0;
      minute_acc  = '0;
      second_acc  = '0;
      fault_flags = '0;
   endfunction

   function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
      return DAYS_BEFORE_MONTH[m] - DAYS_BEFORE_MONTH[m - 1] + ((y % 4 == 0 && m == 2) ? 1 : 0);
   endfunction

   function automatic stamp_type convert_stamp();
      stamp_type       r;
      longint unsigned days;
      longint unsigned month_sec;
      longint unsigned t;
      int unsigned     y;
      int unsigned     m;
      r.epoch = '0;
      y = 32'(year_acc);
      m = 32'(month_acc);
      if (text_pos < TEXT_LEN) begin
         r.status = ST_SHORT;
      end else if (fault_flags[FAULT_SEP]) begin
         r.status = ST_SEPARATOR;
      end else if (fault_flags[FAULT_DIGIT]) begin
         r.status = ST_DIGIT;
      end else if (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12 ||
                   day_acc < 1 || day_acc > 31 || hour_acc > 23 ||
                   minute_acc > 59 || second_acc > 60) begin
         r.status = ST_RANGE;
      end else begin
         days = longint'(y - FIRST_YEAR) * 365 + (y - 1) / 4 - (FIRST_YEAR - 1) / 4
              + DAYS_BEFORE_MONTH[m - 1] + ((y % 4 == 0 && m > 2) ? 1 : 0);
         month_sec = days * DAY_SECONDS;
         t = month_sec + longint'(day_acc - 1) * DAY_SECONDS
           + longint'(hour_acc) * HOUR_SECONDS
           + longint'(minute_acc) * MINUTE_SECONDS + second_acc;
         if (t >= month_sec + longint'(month_length(y, m)) * DAY_SECONDS) begin
            r.status = ST_PAST_END;
         end else begin
            r.status = ST_OK;
            r.epoch  = t[EPOCH_W-1:0];
         end
      end
      return r;
   endfunction

   function automatic void absorb_char(input logic [CHAR_W-1:0] c, input logic last_char);
      logic [3:0] digit;
      if (text_pos < TEXT_LEN) begin
         if (text_pos == POS_DASH_A || text_pos == POS_DASH_B) begin
            if (c != CHAR_DASH) fault_flags[FAULT_SEP] = 1'b1;
         end else if (text_pos == POS_T) begin
            if (c != CHAR_T) fault_flags[FAULT_SEP] = 1'b1;
         end else if (text_pos == POS_COLON_A || text_pos == POS_COLON_B) begin
            if (c != CHAR_COLON) fault_flags[FAULT_SEP] = 1'b1;
         end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
            fault_flags[FAULT_DIGIT] = 1'b1;
         end else begin
            digit = c[3:0];
            if (text_pos < POS_DASH_A) year_acc = YEAR_W'(year_acc * 10 + digit);
            else if (text_pos < POS_DASH_B) month_acc = FIELD_W'(month_acc * 10 + digit);
            else if (text_pos < POS_T) day_acc = FIELD_W'(day_acc * 10 + digit);
            else if (text_pos < POS_COLON_A) hour_acc = FIELD_W'(hour_acc * 10 + digit);
            else if (text_pos < POS_COLON_B) minute_acc = FIELD_W'(minute_acc * 10 + digit);
            else second_acc = FIELD_W'(second_acc * 10 + digit);
         end
         text_pos = text_pos + POS_W'(1);
      end
      if (last_char) begin
         expected_stamps.push_back(convert_stamp());
         clear_state();
      end
   endfunction

   function automatic text_type text_of(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic text_type format_stamp(input int unsigned y, input int unsigned mo,
                                             input int unsigned d, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
      return text_of($sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, d, h, mi, s));
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last_char);
      while (!calm && $urandom_range(99) < STALL_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.character <= c;
      req_bus.last      <= last_char;
      do @(posedge clock); while (!req_bus.ready);
      absorb_char(c, last_char);
      chars_sent++;
   endtask

   task automatic send_text(input text_type text);
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic test_epoch_extremes();
      send_text(text_of("1970-01-01T00:00:00"));
      send_text(text_of("2033-12-31T23:59:59"));
      send_text(text_of("2032-02-29T12:34:56"));
      send_text(text_of("2015-06-15T23:59:60"));
   endtask

   task automatic test_month_end();
      send_text(text_of("2031-02-29T00:00:00"));
      send_text(text_of("2033-04-31T00:00:00"));
      send_text(text_of("2033-12-31T23:59:60"));
   endtask

   task automatic test_short_text();
      send_text(text_of("2"));
      send_text(text_of("1970-01-01T00:00:0"));
      send_text(text_of("19x0-"));
   endtask

   task automatic test_bad_format();
      text_type text;
      send_text(text_of("1970/01-01T00:00:00"));
      send_text(text_of("1970-01-01 00:00:00"));
      send_text(text_of("197a-01-01T00:00:00"));
      send_text(text_of("19a0-01-01T00:00/00"));
      text = text_of("2000-01-01T00:00:00");
      text[POS_COLON_A] = 8'h00;
      send_text(text);
      text = text_of("2000-01-01T00:00:00");
      text[TEXT_LEN - 1] = 8'h00;
      send_text(text);
   endtask

   task automatic test_field_ranges();
      send_text(text_of("1969-12-31T23:59:59"));
      send_text(text_of("2034-01-01T00:00:00"));
      send_text(text_of("2000-00-10T00:00:00"));
      send_text(text_of("2000-13-10T00:00:00"));
      send_text(text_of("2000-01-00T00:00:00"));
      send_text(text_of("2000-01-32T00:00:00"));
      send_text(text_of("2000-01-01T24:00:00"));
      send_text(text_of("2000-01-01T00:60:00"));
      send_text(text_of("2000-01-01T00:00:61"));
      send_text(text_of("9999-99-99T99:99:99"));
   endtask

   task automatic test_trailing_text();
      send_text(text_of("1999-12-31T23:59:59Z"));
      send_text(text_of("2000-01-01T00:00:00+01:00"));
   endtask

   task automatic test_random();
      int unsigned target;
      int unsigned first;
      int unsigned kind;
      int unsigned y, mo, d, h, mi, s;
      int unsigned p;
      text_type    text;
      first  = chars_sent;
      target = chars_sent + RANDOM_CHARS;
      while (chars_sent < target) begin
         calm = (chars_sent - first >= 500 && chars_sent - first < 900);
         kind = $urandom_range(99);
         y  = $urandom_range(LAST_YEAR, FIRST_YEAR);
         mo = $urandom_range(12, 1);
         if ($urandom_range(3) == 0) d = month_length(y, mo) - 1 + $urandom_range(2);
         else d = $urandom_range(month_length(y, mo), 1);
         h  = $urandom_range(23);
         mi = $urandom_range(59);
         s  = $urandom_range(60);
         if ($urandom_range(7) == 0) begin
            h  = 23;
            mi = 59;
         end
         if (kind >= 55 && kind < 65) begin
            y  = $urandom_range(9999);
            mo = $urandom_range(99);
            d  = $urandom_range(99);
            h  = $urandom_range(99);
            mi = $urandom_range(99);
            s  = $urandom_range(99);
         end
         text = format_stamp(y, mo, d, h, mi, s);
         if (kind >= 65 && kind < 75) begin
            p = $urandom_range(TEXT_LEN - 1, 1);
            while (text.size() > p) void'(text.pop_back());
         end else if (kind >= 75 && kind < 85) begin
            case ($urandom_range(4))
               0: p = 32'(POS_DASH_A);
               1: p = 32'(POS_DASH_B);
               2: p = 32'(POS_T);
               3: p = 32'(POS_COLON_A);
               default: p = 32'(POS_COLON_B);
            endcase
            text[p] = CHAR_W'($urandom_range(255));
         end else if (kind >= 85 && kind < 95) begin
            do p = $urandom_range(TEXT_LEN - 1);
            while (p == POS_DASH_A || p == POS_DASH_B || p == POS_T ||
                   p == POS_COLON_A || p == POS_COLON_B);
            text[p] = CHAR_W'($urandom_range(255));
            if ($urandom_range(3) == 0)
               text[$urandom_range(TEXT_LEN - 1)] = CHAR_W'($urandom_range(255));
         end else if (kind >= 95) begin
            text = {};
            repeat ($urandom_range(24, 1)) text.push_back(CHAR_W'($urandom_range(255)));
         end
         if (kind < 65 || (kind >= 75 && kind < 95)) begin
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(5, 1)) text.push_back(CHAR_W'($urandom_range(255)));
         end
         send_text(text);
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= STALL_PERCENT);
   end

   always @(posedge clock) begin
      stamp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_stamps.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: epoch %0d status %0d",
                     $time, rsp_bus.epoch_seconds, rsp_bus.status);
         end else begin
            want = expected_stamps.pop_front();
            stamps_checked++;
            status_seen[want.status]++;
            if (rsp_bus.status !== want.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
            end
            if (rsp_bus.epoch_seconds !== want.epoch) begin
               errors++;
               $display("%0t: epoch_seconds mismatch: expected %0d actual %0d",
                        $time, want.epoch, rsp_bus.epoch_seconds);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, expected_stamps.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.character <= '0;
      req_bus.last      <= 1'b0;
      reset             <= 1'b1;
      calm           = 1'b0;
      errors         = 0;
      chars_sent     = 0;
      stamps_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_epoch_extremes();
      test_month_end();
      test_short_text();
      test_bad_format();
      test_field_ranges();
      test_trailing_text();
      test_random();

      // drop valid after the final beat and drain
      req_bus.valid <= 1'b0;
      while (expected_stamps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d timestamps built from %0d characters", stamps_checked, chars_sent);
      $display("Status mix: %0d ok, %0d short, %0d separator, %0d digit, %0d range, %0d past end",
               status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_SEPARATOR],
               status_seen[ST_DIGIT], status_seen[ST_RANGE], status_seen[ST_PAST_END]);
      if (errors == 0 && expected_stamps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
